// ===== src/tvo_pkg.sv =====
// Shared widths, codes and payload types of the triangle voxel overlap test.
`default_nettype none
package tvo_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 17;
  localparam int IDX_W     = 10;
  localparam int GLOG_W    = 4;
  localparam int RAD_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 31;

  localparam int PW   = IN_W + 1;
  localparam int DW   = PW + 1;
  localparam int MW   = PW;
  localparam int SPW  = 2 * DW;
  localparam int D2W  = 2 * PW + 2;
  localparam int DTW  = 2 * PW + 3;
  localparam int NW   = 2 * PW + 2;
  localparam int NMW  = NW - 1;
  localparam int LIMW = RAD_W + 2;
  localparam int NNW  = 2 * NMW + 2;
  localparam int SDW  = NMW + MW + 2;
  localparam int DOTW = 2 * NMW + 3;
  localparam int SEGW = 2 * D2W + 1;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_VERTEX = 3'd1,
    KIND_EDGE   = 3'd2,
    KIND_FACE   = 3'd3,
    KIND_DEGEN  = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_LOG2 = 2'd0,
    CFG_FACE_RSQ  = 2'd1,
    CFG_EDGE_RSQ  = 2'd2,
    CFG_VERT_RSQ  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0][D2W-1:0]      d2;
    logic [2:0][D2W-1:0]      l2;
    logic [2:0][DTW-1:0]      dt;
    logic [2:0][NW-1:0]       n;
    logic [2:0][2:0][NW-1:0]  cr;
    logic [2:0][DW-1:0]       d;
  } geom_t;

endpackage
`default_nettype wire

// ===== src/tvo_if.sv =====
// Valid/ready channel interfaces for triangle transactions and test results.
`default_nettype none
interface tvo_in_if;
  import tvo_pkg::*;
  logic              valid;
  logic              ready;
  logic [IN_W-1:0]   ax;
  logic [IN_W-1:0]   ay;
  logic [IN_W-1:0]   az;
  logic [IN_W-1:0]   bx;
  logic [IN_W-1:0]   by_coord;
  logic [IN_W-1:0]   bz;
  logic [IN_W-1:0]   cx;
  logic [IN_W-1:0]   cy;
  logic [IN_W-1:0]   cz;
  logic [IDX_W-1:0]  voxel_x;
  logic [IDX_W-1:0]  voxel_y;
  logic [IDX_W-1:0]  voxel_z;
  modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                  voxel_x, voxel_y, voxel_z, input ready);
  modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                voxel_x, voxel_y, voxel_z, output ready);
endinterface

interface tvo_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [2:0] hit_kind;
  modport source (output valid, hit, hit_kind, input ready);
  modport sink (input valid, hit, hit_kind, output ready);
endinterface
`default_nettype wire

// ===== src/triangle_voxel_overlap_test.sv =====
// Top level of the triangle voxel overlap test pipeline.
// Usage:
//   Each in_ch transaction carries one triangle (three vertices, 1.0 = 65536) and one
//   voxel index. Each one yields exactly one out_ch transaction with hit and hit_kind
//   (none, vertex sphere, edge capsule, face slab, or degenerate triangle), in order.
//   The pipeline takes a new transaction every cycle while out_ch is not stalled. The
//   pipeline depth is set by the wide products of the face slab test, which pass
//   through two split multipliers in series.
//   All stages advance together. When out_ch holds a result that is not taken, the
//   whole pipeline holds and in_ch.ready drops in the same cycle; no transaction is
//   lost or repeated, and bubbles are kept in place.
//   The cfg port writes grid_log2, face, edge and vertex squared radii by index; the user
//   must write only while the pipeline is empty, which the block does not enforce.
//   Synchronous reset empties the pipeline and loads the default grid size and radii.
`default_nettype none
module triangle_voxel_overlap_test #(
  parameter int GRID_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tvo_in_if.sink                         in_ch,
  tvo_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tvo_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tvo_pkg::CFG_W-1:0]      cfg_data
);
  import tvo_pkg::*;

  logic                         adv;
  logic [GLOG_W-1:0]            grid_log2_r;
  logic [RAD_W-1:0]             face_rsq_r;
  logic [RAD_W-1:0]             edge_rsq_r;
  logic [RAD_W-1:0]             vert_rsq_r;
  logic [LIMW-1:0]              face_lim;
  logic [LIMW-1:0]              edge_lim;
  logic [LIMW-1:0]              vert_lim;
  logic [2:0][2:0][IN_W-1:0]    vert;
  logic [2:0][IDX_W-1:0]        vox;
  logic                         geom_vld;
  geom_t                        geom;
  logic                         vhit;
  logic                         degen;
  logic [2:0]                   seg_hit;
  logic                         face_hit;
  logic [5:0]                   vld_sr_r;
  logic [5:0]                   vh_sr_r;
  logic [5:0]                   dg_sr_r;
  logic [2:0]                   eh_sr_r;
  logic                         out_vld_r;
  logic                         hit_r;
  kind_t                        kind_r;
  kind_t                        kind_nxt;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  assign face_lim = {face_rsq_r, 2'b00};
  assign edge_lim = {edge_rsq_r, 2'b00};
  assign vert_lim = {vert_rsq_r, 2'b00};

  assign vert[0][0] = in_ch.ax;
  assign vert[0][1] = in_ch.ay;
  assign vert[0][2] = in_ch.az;
  assign vert[1][0] = in_ch.bx;
  assign vert[1][1] = in_ch.by_coord;
  assign vert[1][2] = in_ch.bz;
  assign vert[2][0] = in_ch.cx;
  assign vert[2][1] = in_ch.cy;
  assign vert[2][2] = in_ch.cz;
  assign vox[0]     = in_ch.voxel_x;
  assign vox[1]     = in_ch.voxel_y;
  assign vox[2]     = in_ch.voxel_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_log2_r <= GLOG_W'(8);
      face_rsq_r  <= RAD_W'(16384);
      edge_rsq_r  <= RAD_W'(32768);
      vert_rsq_r  <= RAD_W'(49152);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GRID_LOG2: grid_log2_r <= cfg_data[GLOG_W-1:0];
        CFG_FACE_RSQ:  face_rsq_r  <= cfg_data[RAD_W-1:0];
        CFG_EDGE_RSQ:  edge_rsq_r  <= cfg_data[RAD_W-1:0];
        CFG_VERT_RSQ:  vert_rsq_r  <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  tvo_geom #(.GRID_BITS(GRID_BITS)) u_geom (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(in_ch.valid),
    .grid_log2(grid_log2_r), .vert(vert), .vox(vox),
    .out_vld(geom_vld), .geom(geom)
  );

  for (genvar i = 0; i < 3; i++) begin : g_seg
    localparam int NI = (i == 2) ? 0 : i + 1;
    tvo_seg u_seg (
      .clk(clk), .en(adv), .d2a(geom.d2[i]), .d2b(geom.d2[NI]), .l2(geom.l2[i]),
      .dt(geom.dt[i]), .lim(edge_lim), .hit(seg_hit[i])
    );
  end

  tvo_face u_face (
    .clk(clk), .en(adv), .n(geom.n), .d(geom.d), .cr(geom.cr), .lim(face_lim),
    .hit(face_hit)
  );

  always_comb begin
    vhit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      vhit = vhit | (geom.d2[i] <= D2W'(vert_lim));
    end
    degen = (geom.n == '0);
    if (dg_sr_r[5]) begin
      kind_nxt = KIND_DEGEN;
    end else if (vh_sr_r[5]) begin
      kind_nxt = KIND_VERTEX;
    end else if (eh_sr_r[2]) begin
      kind_nxt = KIND_EDGE;
    end else if (face_hit) begin
      kind_nxt = KIND_FACE;
    end else begin
      kind_nxt = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_sr_r  <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_sr_r  <= {vld_sr_r[4:0], geom_vld};
      out_vld_r <= vld_sr_r[5];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vh_sr_r <= {vh_sr_r[4:0], vhit};
      dg_sr_r <= {dg_sr_r[4:0], degen};
      eh_sr_r <= {eh_sr_r[1:0], |seg_hit};
      kind_r  <= kind_nxt;
      hit_r   <= !dg_sr_r[5] && (vh_sr_r[5] || eh_sr_r[2] || face_hit);
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.hit      = hit_r;
  assign out_ch.hit_kind = kind_r;

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_sr_r))
    else $error("pipeline valid bits moved during a stall");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r == $past(vld_sr_r[5]))
    else $error("output register did not take the last stage");

  a_vertex_kind: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_sr_r[5] && vh_sr_r[5] && !dg_sr_r[5] |=> kind_r == KIND_VERTEX && hit_r)
    else $error("vertex hit not reported as vertex");
endmodule
`default_nettype wire

// ===== src/tvo_mul.sv =====
// Two-stage unsigned multiplier built from four registered half-width partial products.
`default_nettype none
module tvo_mul #(
  parameter int WA = 38,
  parameter int WB = 38
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);
  localparam int AL = WA / 2;
  localparam int AH = WA - AL;
  localparam int BL = WB / 2;
  localparam int BH = WB - BL;
  localparam int WP = WA + WB;

  logic [AL+BL-1:0] ll_r;
  logic [AL+BH-1:0] lh_r;
  logic [AH+BL-1:0] hl_r;
  logic [AH+BH-1:0] hh_r;
  logic [WP-1:0]    p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a[AL-1:0] * b[BL-1:0];
      lh_r <= a[AL-1:0] * b[WB-1:BL];
      hl_r <= a[WA-1:AL] * b[BL-1:0];
      hh_r <= a[WA-1:AL] * b[WB-1:BL];
      p_r  <= WP'(ll_r) + (WP'(lh_r) << BL) + (WP'(hl_r) << AL) + (WP'(hh_r) << (AL + BL));
    end
  end

  assign p = p_r;
endmodule
`default_nettype wire

// ===== src/tvo_geom.sv =====
// Front stages: voxel center, difference vectors, small products and their sums.
`default_nettype none
module tvo_geom #(
  parameter int GRID_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic [tvo_pkg::GLOG_W-1:0]          grid_log2,
  input  logic [2:0][2:0][tvo_pkg::IN_W-1:0]  vert,
  input  logic [2:0][tvo_pkg::IDX_W-1:0]      vox,
  output logic                                out_vld,
  output tvo_pkg::geom_t                      geom
);
  import tvo_pkg::*;

  localparam int GMAX = (GRID_BITS < FRAC_BITS) ? GRID_BITS : FRAC_BITS;
  localparam int SHW  = GLOG_W + 1;
  localparam int NX[3] = '{1, 2, 0};
  localparam int UA[6] = '{1, 2, 2, 0, 0, 1};
  localparam int VA[6] = '{2, 1, 0, 2, 1, 0};

  logic [3:0]               vld_r;
  logic [GLOG_W-1:0]        g_eff;
  logic [2:0][IDX_W-1:0]    idx_m;
  logic [2:0][PW-1:0]       c_nxt;
  logic [PW-1:0]            v1_r  [3][3];
  logic [PW-1:0]            c1_r  [3];
  logic signed [DW-1:0]     pa2_r [3][3];
  logic signed [DW-1:0]     ab2_r [3][3];
  logic signed [DW-1:0]     e12_r [3];
  logic signed [SPW-1:0]    sq3_r [3][3];
  logic signed [SPW-1:0]    ll3_r [3][3];
  logic signed [SPW-1:0]    dt3_r [3][3];
  logic signed [SPW-1:0]    nc3_r [6];
  logic signed [SPW-1:0]    cp3_r [3][6];
  logic signed [DW-1:0]     d3_r  [3];
  geom_t                    geom_r;

  always_comb begin
    if (grid_log2 < GLOG_W'(2)) begin
      g_eff = GLOG_W'(2);
    end else if (grid_log2 > GLOG_W'(GMAX)) begin
      g_eff = GLOG_W'(GMAX);
    end else begin
      g_eff = grid_log2;
    end
    for (int k = 0; k < 3; k++) begin
      for (int b = 0; b < IDX_W; b++) begin
        idx_m[k][b] = vox[k][b] & (GLOG_W'(b) < g_eff);
      end
      c_nxt[k] = PW'({idx_m[k], 1'b1}) << (SHW'(FRAC_BITS) - SHW'(g_eff));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c1_r[i] <= c_nxt[i];
        e12_r[i] <= DW'(v1_r[2][i]) - DW'(v1_r[0][i]);
        d3_r[i] <= pa2_r[0][i];
        geom_r.d[i] <= d3_r[i];
        geom_r.n[i] <= nc3_r[2 * i] - nc3_r[2 * i + 1];
        for (int k = 0; k < 3; k++) begin
          v1_r[i][k]  <= {vert[i][k], 1'b0};
          pa2_r[i][k] <= DW'(c1_r[k]) - DW'(v1_r[i][k]);
          ab2_r[i][k] <= DW'(v1_r[NX[i]][k]) - DW'(v1_r[i][k]);
          sq3_r[i][k] <= pa2_r[i][k] * pa2_r[i][k];
          ll3_r[i][k] <= ab2_r[i][k] * ab2_r[i][k];
          dt3_r[i][k] <= pa2_r[i][k] * ab2_r[i][k];
          geom_r.cr[i][k] <= cp3_r[i][2 * k] - cp3_r[i][2 * k + 1];
        end
        for (int j = 0; j < 6; j++) begin
          cp3_r[i][j] <= ab2_r[i][UA[j]] * pa2_r[i][VA[j]];
        end
        geom_r.d2[i] <= D2W'(sq3_r[i][0]) + D2W'(sq3_r[i][1]) + D2W'(sq3_r[i][2]);
        geom_r.l2[i] <= D2W'(ll3_r[i][0]) + D2W'(ll3_r[i][1]) + D2W'(ll3_r[i][2]);
        geom_r.dt[i] <= DTW'(dt3_r[i][0]) + DTW'(dt3_r[i][1]) + DTW'(dt3_r[i][2]);
      end
      for (int j = 0; j < 6; j++) begin
        nc3_r[j] <= ab2_r[0][UA[j]] * e12_r[VA[j]];
      end
    end
  end

  assign out_vld = vld_r[3];
  assign geom    = geom_r;
endmodule
`default_nettype wire

// ===== src/tvo_seg.sv =====
// Edge capsule test: squared distance from the voxel center to one clamped segment.
`default_nettype none
module tvo_seg (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tvo_pkg::D2W-1:0]    d2a,
  input  logic [tvo_pkg::D2W-1:0]    d2b,
  input  logic [tvo_pkg::D2W-1:0]    l2,
  input  logic [tvo_pkg::DTW-1:0]    dt,
  input  logic [tvo_pkg::LIMW-1:0]   lim,
  output logic                       hit
);
  import tvo_pkg::*;

  logic                    short_nxt;
  logic                    short_hit_nxt;
  logic                    short5_r;
  logic                    short6_r;
  logic                    sh5_r;
  logic                    sh6_r;
  logic                    hit_r;
  logic [2*D2W-1:0]        lhs;
  logic [LIMW+D2W-1:0]     lim_l2;
  logic [2*D2W-1:0]        dt_sq;

  always_comb begin
    short_nxt     = 1'b1;
    short_hit_nxt = 1'b0;
    if (l2 == '0 || $signed(dt) <= 0) begin
      short_hit_nxt = d2a <= D2W'(lim);
    end else if (dt >= DTW'(l2)) begin
      short_hit_nxt = d2b <= D2W'(lim);
    end else begin
      short_nxt = 1'b0;
    end
  end

  tvo_mul #(.WA(D2W), .WB(D2W)) u_lhs (
    .clk(clk), .en(en), .a(d2a), .b(l2), .p(lhs)
  );

  tvo_mul #(.WA(LIMW), .WB(D2W)) u_lim (
    .clk(clk), .en(en), .a(lim), .b(l2), .p(lim_l2)
  );

  tvo_mul #(.WA(D2W), .WB(D2W)) u_dt (
    .clk(clk), .en(en), .a(dt[D2W-1:0]), .b(dt[D2W-1:0]), .p(dt_sq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      short5_r <= short_nxt;
      sh5_r    <= short_hit_nxt;
      short6_r <= short5_r;
      sh6_r    <= sh5_r;
      hit_r    <= short6_r ? sh6_r : (SEGW'(lhs) <= SEGW'(lim_l2) + SEGW'(dt_sq));
    end
  end

  assign hit = hit_r;
endmodule
`default_nettype wire

// ===== src/tvo_face.sv =====
// Face slab test: plane distance against the slab and the inside-triangle edge signs.
`default_nettype none
module tvo_face (
  input  logic                                clk,
  input  logic                                en,
  input  logic [2:0][tvo_pkg::NW-1:0]         n,
  input  logic [2:0][tvo_pkg::DW-1:0]         d,
  input  logic [2:0][2:0][tvo_pkg::NW-1:0]    cr,
  input  logic [tvo_pkg::LIMW-1:0]            lim,
  output logic                                hit
);
  import tvo_pkg::*;

  logic [2:0][NMW-1:0]          n_mag;
  logic [2:0][MW-1:0]           d_mag;
  logic [2:0][2:0][NMW-1:0]     cr_mag;
  logic [2:0]                   nd_sgn;
  logic [2:0][2:0]              cn_sgn;
  logic [2:0]                   nd_sgn5_r;
  logic [2:0]                   nd_sgn6_r;
  logic [2:0][2:0]              cn_sgn5_r;
  logic [2:0][2:0]              cn_sgn6_r;
  logic [2:0][2*NMW-1:0]        nsq;
  logic [2:0][NMW+MW-1:0]       nd;
  logic [2:0][2:0][2*NMW-1:0]   cn;
  logic [SDW:0]                 sd_sum;
  logic [SDW-1:0]               sd_abs;
  logic [NNW-1:0]               nn_nxt;
  logic [DOTW-1:0]              dot [3];
  logic                         pos_ok;
  logic                         neg_ok;
  logic [NNW-1:0]               nn7_r;
  logic [SDW-1:0]               sd7_r;
  logic                         in7_r;
  logic                         in8_r;
  logic                         in9_r;
  logic                         hit_r;
  logic [2*SDW-1:0]             sd_sq;
  logic [NNW+LIMW-1:0]          nn_lim;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_mag[k]  = NMW'(n[k][NW-1] ? -n[k] : n[k]);
      d_mag[k]  = MW'(d[k][DW-1] ? -d[k] : d[k]);
      nd_sgn[k] = n[k][NW-1] ^ d[k][DW-1];
      for (int i = 0; i < 3; i++) begin
        cr_mag[i][k] = NMW'(cr[i][k][NW-1] ? -cr[i][k] : cr[i][k]);
        cn_sgn[i][k] = cr[i][k][NW-1] ^ n[k][NW-1];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    tvo_mul #(.WA(NMW), .WB(NMW)) u_nsq (
      .clk(clk), .en(en), .a(n_mag[k]), .b(n_mag[k]), .p(nsq[k])
    );
    tvo_mul #(.WA(NMW), .WB(MW)) u_nd (
      .clk(clk), .en(en), .a(n_mag[k]), .b(d_mag[k]), .p(nd[k])
    );
    for (genvar i = 0; i < 3; i++) begin : g_edge
      tvo_mul #(.WA(NMW), .WB(NMW)) u_cn (
        .clk(clk), .en(en), .a(cr_mag[i][k]), .b(n_mag[k]), .p(cn[i][k])
      );
    end
  end

  always_comb begin
    nn_nxt = NNW'(nsq[0]) + NNW'(nsq[1]) + NNW'(nsq[2]);
    sd_sum = '0;
    for (int k = 0; k < 3; k++) begin
      if (nd_sgn6_r[k]) begin
        sd_sum = sd_sum - (SDW + 1)'(nd[k]);
      end else begin
        sd_sum = sd_sum + (SDW + 1)'(nd[k]);
      end
    end
    sd_abs = SDW'(sd_sum[SDW] ? -sd_sum : sd_sum);
    pos_ok = 1'b1;
    neg_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      dot[i] = '0;
      for (int k = 0; k < 3; k++) begin
        if (cn_sgn6_r[i][k]) begin
          dot[i] = dot[i] - DOTW'(cn[i][k]);
        end else begin
          dot[i] = dot[i] + DOTW'(cn[i][k]);
        end
      end
      if (dot[i][DOTW-1]) begin
        pos_ok = 1'b0;
      end else if (dot[i] != '0) begin
        neg_ok = 1'b0;
      end
    end
  end

  tvo_mul #(.WA(SDW), .WB(SDW)) u_sd (
    .clk(clk), .en(en), .a(sd7_r), .b(sd7_r), .p(sd_sq)
  );

  tvo_mul #(.WA(NNW), .WB(LIMW)) u_nn (
    .clk(clk), .en(en), .a(nn7_r), .b(lim), .p(nn_lim)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      nd_sgn5_r <= nd_sgn;
      nd_sgn6_r <= nd_sgn5_r;
      cn_sgn5_r <= cn_sgn;
      cn_sgn6_r <= cn_sgn5_r;
      nn7_r     <= nn_nxt;
      sd7_r     <= sd_abs;
      in7_r     <= pos_ok | neg_ok;
      in8_r     <= in7_r;
      in9_r     <= in8_r;
      hit_r     <= in9_r && (sd_sq <= (2 * SDW)'(nn_lim));
    end
  end

  assign hit = hit_r;
endmodule
`default_nettype wire

// ===== verif/triangle_voxel_overlap_test_test.sv =====
// Self-checking testbench for the triangle voxel overlap test with random handshake stalls.
`timescale 1ns / 1ps
module triangle_voxel_overlap_test_test;
  import tvo_pkg::*;

  typedef logic signed [191:0] wide_t;
  typedef wide_t vec_t [3];

  typedef struct packed {
    logic [8:0][IN_W-1:0]  pos;
    logic [2:0][IDX_W-1:0] vox;
  } tri_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } verdict_t;

  localparam int LIMIT = 300000;
  localparam int COORD_MAX = (1 << IN_W) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  tvo_in_if in_ch();
  tvo_out_if out_ch();

  triangle_voxel_overlap_test dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  tri_t triangle_q[$];
  verdict_t verdict_q[$];
  logic [3:0] grid_reg = 4'd8;
  logic [RAD_W-1:0] face_rsq = 31'd16384;
  logic [RAD_W-1:0] edge_rsq = 31'd32768;
  logic [RAD_W-1:0] vert_rsq = 31'd49152;
  tri_t cur_tri;
  logic in_fire = 1'b0;
  int idle_pct = 32;
  int errors = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  function automatic vec_t sub_of(vec_t a, vec_t b);
    vec_t r;
    for (int k = 0; k < 3; k++) r[k] = a[k] - b[k];
    return r;
  endfunction

  function automatic wide_t dot_of(vec_t a, vec_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic vec_t cross_of(vec_t u, vec_t w);
    vec_t r;
    r[0] = u[1] * w[2] - u[2] * w[1];
    r[1] = u[2] * w[0] - u[0] * w[2];
    r[2] = u[0] * w[1] - u[1] * w[0];
    return r;
  endfunction

  function automatic logic capsule_hit(vec_t p, vec_t a, vec_t b, wide_t lim);
    vec_t ab, pa;
    wide_t l2, dt, da;
    ab = sub_of(b, a);
    pa = sub_of(p, a);
    l2 = dot_of(ab, ab);
    dt = dot_of(pa, ab);
    da = dot_of(pa, pa);
    if (l2 == 0 || dt <= 0) return da <= lim;
    if (dt >= l2) return dot_of(sub_of(p, b), sub_of(p, b)) <= lim;
    return da * l2 <= lim * l2 + dt * dt;
  endfunction

  function automatic verdict_t predict_overlap(tri_t t);
    vec_t v[3];
    vec_t ctr, n, e, pr, cr;
    wide_t sd, nn, vr, er, fr, idx, s;
    int g;
    logic pos_ok, neg_ok;
    kind_t kind;
    verdict_t r;
    g = grid_reg;
    if (g < 2) g = 2;
    if (g > 10) g = 10;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) begin
        v[i][k] = t.pos[i * 3 + k];
        v[i][k] = v[i][k] <<< 1;
      end
    for (int k = 0; k < 3; k++) begin
      idx = t.vox[k] & ((1 << g) - 1);
      ctr[k] = (2 * idx + 1) <<< (FRAC_BITS - g);
    end
    n = cross_of(sub_of(v[1], v[0]), sub_of(v[2], v[0]));
    kind = KIND_NONE;
    vr = vert_rsq;
    er = edge_rsq;
    fr = face_rsq;
    vr = vr <<< 2;
    er = er <<< 2;
    fr = fr <<< 2;
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
      kind = KIND_DEGEN;
    end else begin
      for (int i = 0; i < 3; i++)
        if (kind == KIND_NONE && dot_of(sub_of(ctr, v[i]), sub_of(ctr, v[i])) <= vr)
          kind = KIND_VERTEX;
      for (int i = 0; i < 3; i++)
        if (kind == KIND_NONE && capsule_hit(ctr, v[i], v[(i + 1) % 3], er))
          kind = KIND_EDGE;
      if (kind == KIND_NONE) begin
        sd = dot_of(n, sub_of(ctr, v[0]));
        if (sd < 0) sd = -sd;
        nn = dot_of(n, n);
        if (sd * sd <= nn * fr) begin
          pos_ok = 1'b1;
          neg_ok = 1'b1;
          for (int i = 0; i < 3; i++) begin
            e = sub_of(v[(i + 1) % 3], v[i]);
            pr = sub_of(ctr, v[i]);
            cr = cross_of(e, pr);
            s = dot_of(cr, n);
            if (s < 0) pos_ok = 1'b0;
            if (s > 0) neg_ok = 1'b0;
          end
          if (pos_ok || neg_ok) kind = KIND_FACE;
        end
      end
    end
    r.kind = kind;
    r.hit = (kind == KIND_VERTEX || kind == KIND_EDGE || kind == KIND_FACE);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic enqueue_tri(input tri_t t);
    triangle_q = {triangle_q, t};
  endtask

  // Sampling and checking of both channels.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      verdict_q = {verdict_q, predict_overlap(cur_tri)};
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        verdict_t want;
        want = verdict_q.pop_front();
        if (out_ch.hit !== want.hit)
          report_mismatch($sformatf("hit %b, expected %b", out_ch.hit, want.hit));
        if (out_ch.hit_kind !== want.kind)
          report_mismatch($sformatf("hit_kind %0d, expected %0d", out_ch.hit_kind, want.kind));
      end
    end
    if (cycles > LIMIT) begin
      $display("triangle_voxel_overlap_test test failed");
      $finish;
    end
  end

  // Input driver and result-side stalls, changed at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
      in_ch.ax <= '0; in_ch.ay <= '0; in_ch.az <= '0;
      in_ch.bx <= '0; in_ch.by_coord <= '0; in_ch.bz <= '0;
      in_ch.cx <= '0; in_ch.cy <= '0; in_ch.cz <= '0;
      in_ch.voxel_x <= '0; in_ch.voxel_y <= '0; in_ch.voxel_z <= '0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
      if (!in_ch.valid || in_fire) begin
        if (triangle_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_tri = triangle_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.ax <= cur_tri.pos[0];
          in_ch.ay <= cur_tri.pos[1];
          in_ch.az <= cur_tri.pos[2];
          in_ch.bx <= cur_tri.pos[3];
          in_ch.by_coord <= cur_tri.pos[4];
          in_ch.bz <= cur_tri.pos[5];
          in_ch.cx <= cur_tri.pos[6];
          in_ch.cy <= cur_tri.pos[7];
          in_ch.cz <= cur_tri.pos[8];
          in_ch.voxel_x <= cur_tri.vox[0];
          in_ch.voxel_y <= cur_tri.vox[1];
          in_ch.voxel_z <= cur_tri.vox[2];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic tri_t make_tri(int a0, a1, a2, b0, b1, b2, c0, c1, c2, x, y, z);
    tri_t t;
    t.pos = '{c2, c1, c0, b2, b1, b0, a2, a1, a0};
    t.vox = '{z, y, x};
    return t;
  endfunction

  function automatic int clip_coord(int val);
    if (val < 0) return 0;
    if (val > COORD_MAX) return COORD_MAX;
    return val;
  endfunction

  function automatic tri_t random_tri();
    tri_t t;
    int mode, g, spread, dx, dy, dz;
    int ctr[3];
    mode = $urandom_range(99);
    g = grid_reg;
    if (g < 2) g = 2;
    if (g > 10) g = 10;
    for (int k = 0; k < 3; k++) begin
      t.vox[k] = $urandom_range((1 << g) - 1);
      if ($urandom_range(9) == 0) t.vox[k] = $urandom_range(1023);
      ctr[k] = ((2 * (t.vox[k] & ((1 << g) - 1)) + 1) << (FRAC_BITS - g)) >> 1;
    end
    if (mode < 10) begin
      for (int j = 0; j < 9; j++) t.pos[j] = $urandom_range(COORD_MAX);
    end else if (mode < 18) begin
      // Collinear or coincident vertices.
      dx = $urandom_range(512) - 256;
      dy = $urandom_range(512) - 256;
      dz = $urandom_range(512) - 256;
      if ($urandom_range(3) == 0) begin
        dx = 0; dy = 0; dz = 0;
      end
      for (int k = 0; k < 3; k++) t.pos[k] = ctr[k] + 600;
      t.pos[3] = t.pos[0] + dx; t.pos[4] = t.pos[1] + dy; t.pos[5] = t.pos[2] + dz;
      t.pos[6] = t.pos[0] - dx; t.pos[7] = t.pos[1] - dy; t.pos[8] = t.pos[2] - dz;
    end else begin
      spread = 1 << $urandom_range(5, 13);
      for (int j = 0; j < 9; j++)
        t.pos[j] = clip_coord(ctr[j % 3] + $urandom_range(2 * spread) - spread);
    end
    return t;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CFG_GRID_LOG2: grid_reg = val[3:0];
      CFG_FACE_RSQ: face_rsq = val;
      CFG_EDGE_RSQ: edge_rsq = val;
      default: vert_rsq = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (triangle_q.size() != 0 || in_ch.valid || verdict_q.size() != 0)
      @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) enqueue_tri(random_tri());
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed cases at the reset settings: grid 256, voxel 128 center is 0.5 + 1/512.
    enqueue_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    enqueue_tri(make_tri(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0,
                         0, COORD_MAX, 0, 1023, 1023, 1023));
    enqueue_tri(make_tri(100, 100, 100, 300, 300, 300, 500, 500, 500, 3, 3, 3));
    enqueue_tri(make_tri(32896, 32896, 32896, 40000, 32896, 32896,
                         32896, 40000, 32896, 128, 128, 128));
    enqueue_tri(make_tri(30000, 32896, 32896, 36000, 32896, 32896,
                         33000, 36000, 32896, 128, 128, 128));
    enqueue_tri(make_tri(30000, 30000, 32896, 36000, 30000, 32896,
                         33000, 36000, 32896, 128, 128, 128));
    enqueue_tri(make_tri(30000, 30000, 32950, 36000, 30000, 32950,
                         33000, 36000, 32950, 128, 128, 128));
    enqueue_tri(make_tri(30000, 30000, 40000, 36000, 30000, 40000,
                         33000, 36000, 40000, 128, 128, 128));
    enqueue_tri(make_tri(65536, 65536, 65536, 131071, 70000, 65536,
                         70000, 131071, 65536, 255, 255, 255));
    enqueue_tri(make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 1023, 0, 512));
    enqueue_tri(make_tri(128, 128, 128, 128, 128, 128, 5000, 5000, 5000, 0, 0, 0));
    enqueue_tri(make_tri(131071, 0, 131071, 0, 131071, 0, 131071, 131071, 0,
                         682, 341, 1023));
    wait_drained();
    run_random(170);

    write_reg(CFG_GRID_LOG2, 2);
    write_reg(CFG_FACE_RSQ, 0);
    write_reg(CFG_EDGE_RSQ, 0);
    write_reg(CFG_VERT_RSQ, 0);
    run_random(100);
    // The sender holds off until the pipeline is empty before going on.
    run_random(100);

    write_reg(CFG_GRID_LOG2, 10);
    write_reg(CFG_FACE_RSQ, 31'd1073741824);
    write_reg(CFG_EDGE_RSQ, 31'd1073741824);
    write_reg(CFG_VERT_RSQ, 31'd1073741824);
    idle_pct = 0;
    run_random(150);
    idle_pct = 32;
    run_random(50);

    write_reg(CFG_GRID_LOG2, 0);
    write_reg(CFG_FACE_RSQ, 31'h7FFF_FFFF);
    write_reg(CFG_EDGE_RSQ, 31'd4096);
    write_reg(CFG_VERT_RSQ, 31'd1024);
    run_random(200);

    write_reg(CFG_GRID_LOG2, 15);
    write_reg(CFG_FACE_RSQ, 31'd262144);
    write_reg(CFG_EDGE_RSQ, 31'h7FFF_FFFF);
    write_reg(CFG_VERT_RSQ, 31'd2000000);
    run_random(200);

    write_reg(CFG_GRID_LOG2, CFG_W'($urandom_range(3, 9)));
    write_reg(CFG_FACE_RSQ, CFG_W'($urandom_range(200000)));
    write_reg(CFG_EDGE_RSQ, CFG_W'($urandom_range(400000)));
    write_reg(CFG_VERT_RSQ, CFG_W'($urandom_range(800000)));
    run_random(360);

    if (errors == 0) begin
      $display("triangle_voxel_overlap_test test passed");
    end else begin
      $display("triangle_voxel_overlap_test test failed");
    end
    $finish;
  end

endmodule
